// File: rtl/ctt_pkg.sv
`timescale 1ns / 1ps
// ctt_pkg: shared types, codes and helpers for the catcode byte tokenizer.
// No dependencies; imported by the interface users, core and top level.
package ctt_pkg;

	localparam int unsigned CATEGORY_ENTRIES_DEF = 256;
	localparam int unsigned POSITION_WIDTH_DEF   = 32;

	localparam int unsigned CAT_W  = 4;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned OUT_W  = 32;

	// Category codes, TeX numbering
	localparam logic [CAT_W-1:0] CAT_ESCAPE  = 4'd0;
	localparam logic [CAT_W-1:0] CAT_IGNORE  = 4'd9;
	localparam logic [CAT_W-1:0] CAT_SPACE   = 4'd10;
	localparam logic [CAT_W-1:0] CAT_LETTER  = 4'd11;
	localparam logic [CAT_W-1:0] CAT_COMMENT = 4'd14;

	localparam logic [BYTE_W-1:0] NL_BYTE = 8'h0A;
	localparam logic [LEN_W-1:0]  LEN_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		ACT_BYTE      = 2'd0,
		ACT_WRITE_CAT = 2'd1,
		ACT_END       = 2'd2,
		ACT_RESTART   = 2'd3
	} action_t;

	typedef enum logic [5:0] {
		PH_NORMAL   = 6'b000001,
		PH_COMMENT  = 6'b000010,
		PH_ESC_SEEN = 6'b000100,
		PH_WORD     = 6'b001000,
		PH_ESC_MB   = 6'b010000,
		PH_CHAR_MB  = 6'b100000
	} phase_t;

	typedef enum logic [2:0] {
		MODE_NEWLINE = 3'b001,
		MODE_SKIP    = 3'b010,
		MODE_MIDDLE  = 3'b100
	} mode_t;

	typedef struct packed {
		action_t             action;
		logic [BYTE_W-1:0]   byte_value;
		logic [CAT_W-1:0]    category_value;
	} req_t;

	typedef struct packed {
		logic [CAT_W-1:0] category;
		logic             is_newline;
		logic [OUT_W-1:0] start_offset;
		logic [LEN_W-1:0] byte_length;
		logic [OUT_W-1:0] line;
		logic [OUT_W-1:0] column;
		logic             end_marker;
		logic             last;
	} tok_t;

	// One processed request, as seen by the core
	typedef struct packed {
		action_t           action;
		logic [BYTE_W-1:0] byte_value;
		logic [CAT_W-1:0]  cat;
	} step_t;

	// Up to two tokens per request
	typedef struct packed {
		logic [1:0]     count;
		tok_t [1:0]     tok;
	} emit_t;

	// UTF-8 lead length: 1..4
	function automatic logic [2:0] lead_length(logic [BYTE_W-1:0] b);
		logic [2:0] n;
		n = 3'd1;
		if (b[7:5] == 3'b110)
			n = 3'd2;
		else if (b[7:4] == 4'b1110)
			n = 3'd3;
		else if (b[7:3] == 5'b11110)
			n = 3'd4;
		return n;
	endfunction

endpackage

// File: rtl/ctt_chan_if.sv
`timescale 1ns / 1ps
// ctt_chan_if: valid/ready channel carrying one payload of a given type.
// No dependencies; payload type is set per instance.
interface ctt_chan_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// File: rtl/ctt_ram.sv
`timescale 1ns / 1ps
// ctt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ctt_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// File: rtl/ctt_core.sv
`timescale 1ns / 1ps
// ctt_core: scanner state and the per-request next-state / token logic.
// Depends on ctt_pkg.
module ctt_core import ctt_pkg::*; #(
	parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  step_t step,
	output emit_t emit
);
	localparam int unsigned PW = POSITION_WIDTH;

	mode_t           mode_q, n_mode;
	phase_t          phase_q, n_phase;
	logic [1:0]      cont_q, n_cont;
	logic [PW-1:0]   offset_q, n_offset;
	logic [PW-1:0]   line_q, n_line;
	logic [PW-1:0]   column_q, n_column;
	logic [PW-1:0]   pstart_q, n_pstart;
	logic [PW-1:0]   pline_q, n_pline;
	logic [PW-1:0]   pcol_q, n_pcol;
	logic [CAT_W-1:0] pcat_q, n_pcat;
	logic [LEN_W-1:0] plen_q, n_plen;

	logic [2:0] lead;
	logic       multi;
	logic       fresh;
	emit_t      em;

	function automatic logic [PW-1:0] inc_sat(logic [PW-1:0] v);
		return (v == '1) ? v : v + PW'(1);
	endfunction

	function automatic logic [OUT_W-1:0] sat32(logic [PW-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
	endfunction

	function automatic logic [OUT_W-1:0] low32(logic [PW-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[31:0];
	endfunction

	function automatic tok_t mk_tok(logic [CAT_W-1:0] cat, logic nl, logic [PW-1:0] start,
			logic [LEN_W-1:0] len, logic [PW-1:0] ln, logic [PW-1:0] col, logic endm);
		tok_t t;
		t.category     = cat;
		t.is_newline   = nl;
		t.start_offset = low32(start);
		t.byte_length  = len;
		t.line         = sat32(ln);
		t.column       = sat32(col);
		t.end_marker   = endm;
		t.last         = 1'b0;
		return t;
	endfunction

	function automatic emit_t push(emit_t e, tok_t t);
		emit_t r;
		r = e;
		r.tok[e.count[0]] = t;
		r.count = e.count + 2'd1;
		return r;
	endfunction

	assign lead  = lead_length(step.byte_value);
	assign multi = (lead > 3'd1);

	always_comb begin
		n_mode   = mode_q;
		n_phase  = phase_q;
		n_cont   = cont_q;
		n_offset = offset_q;
		n_line   = line_q;
		n_column = column_q;
		n_pstart = pstart_q;
		n_pline  = pline_q;
		n_pcol   = pcol_q;
		n_pcat   = pcat_q;
		n_plen   = plen_q;
		em       = '0;
		fresh    = 1'b0;

		unique case (step.action)
			ACT_BYTE: begin
				unique case (phase_q) inside
					PH_COMMENT: begin
						if (step.byte_value != NL_BYTE) begin
							n_offset = offset_q + PW'(1);
							n_column = inc_sat(column_q);
						end else begin
							n_phase = PH_NORMAL;
							fresh   = 1'b1;
						end
					end
					PH_ESC_SEEN: begin
						n_offset = offset_q + PW'(1);
						n_column = inc_sat(column_q);
						if (plen_q != LEN_MAX)
							n_plen = plen_q + LEN_W'(1);
						if (step.cat == CAT_LETTER) begin
							n_phase = PH_WORD;
						end else if (multi) begin
							n_cont  = 2'(lead - 3'd1);
							n_phase = PH_ESC_MB;
						end else begin
							n_mode  = MODE_MIDDLE;
							n_phase = PH_NORMAL;
							em = push(em, mk_tok(n_pcat, 1'b0, n_pstart, n_plen, n_pline,
								n_pcol, 1'b0));
						end
					end
					PH_WORD: begin
						if (step.cat == CAT_LETTER) begin
							n_offset = offset_q + PW'(1);
							n_column = inc_sat(column_q);
							if (plen_q != LEN_MAX)
								n_plen = plen_q + LEN_W'(1);
						end else begin
							// word closes, the byte itself is scanned afresh
							n_mode  = MODE_SKIP;
							n_phase = PH_NORMAL;
							em = push(em, mk_tok(n_pcat, 1'b0, n_pstart, n_plen, n_pline,
								n_pcol, 1'b0));
							fresh = 1'b1;
						end
					end
					PH_ESC_MB, PH_CHAR_MB: begin
						n_offset = offset_q + PW'(1);
						if (plen_q != LEN_MAX)
							n_plen = plen_q + LEN_W'(1);
						if (cont_q != 2'd0)
							n_cont = cont_q - 2'd1;
						if (n_cont == 2'd0) begin
							n_mode  = MODE_MIDDLE;
							n_phase = PH_NORMAL;
							em = push(em, mk_tok(n_pcat, 1'b0, n_pstart, n_plen, n_pline,
								n_pcol, 1'b0));
						end
					end
					default: begin
						n_phase = PH_NORMAL;
						fresh   = 1'b1;
					end
				endcase

				if (fresh) begin
					if (step.byte_value == NL_BYTE) begin
						em = push(em, mk_tok(CAT_SPACE, 1'b1, n_offset, LEN_W'(1), n_line,
							n_column, 1'b0));
						n_offset = n_offset + PW'(1);
						n_line   = inc_sat(n_line);
						n_column = PW'(1);
						n_mode   = MODE_NEWLINE;
					end else if (step.cat == CAT_SPACE) begin
						if (n_mode == MODE_MIDDLE) begin
							em = push(em, mk_tok(CAT_SPACE, 1'b0, n_offset, LEN_W'(1), n_line,
								n_column, 1'b0));
							n_mode = MODE_SKIP;
						end
						n_offset = n_offset + PW'(1);
						n_column = inc_sat(n_column);
					end else if (step.cat == CAT_IGNORE) begin
						n_offset = n_offset + PW'(1);
						n_column = inc_sat(n_column);
					end else if (step.cat == CAT_COMMENT) begin
						n_offset = n_offset + PW'(1);
						n_column = inc_sat(n_column);
						n_mode   = MODE_SKIP;
						n_phase  = PH_COMMENT;
					end else begin
						// open a token: escape, or an ordinary character
						n_pstart = n_offset;
						n_pline  = n_line;
						n_pcol   = n_column;
						n_pcat   = step.cat;
						n_plen   = LEN_W'(1);
						n_offset = n_offset + PW'(1);
						n_column = inc_sat(n_column);
						if (step.cat == CAT_ESCAPE) begin
							n_phase = PH_ESC_SEEN;
						end else if (multi) begin
							n_cont  = 2'(lead - 3'd1);
							n_phase = PH_CHAR_MB;
						end else begin
							n_mode = MODE_MIDDLE;
							em = push(em, mk_tok(n_pcat, 1'b0, n_pstart, n_plen, n_pline,
								n_pcol, 1'b0));
						end
					end
				end
			end
			ACT_END: begin
				unique case (phase_q) inside
					PH_ESC_SEEN, PH_ESC_MB, PH_CHAR_MB: begin
						n_mode = MODE_MIDDLE;
						em = push(em, mk_tok(pcat_q, 1'b0, pstart_q, plen_q, pline_q,
							pcol_q, 1'b0));
					end
					PH_WORD: begin
						n_mode = MODE_SKIP;
						em = push(em, mk_tok(pcat_q, 1'b0, pstart_q, plen_q, pline_q,
							pcol_q, 1'b0));
					end
					default: begin
					end
				endcase
				n_phase = PH_NORMAL;
				n_cont  = 2'd0;
				em = push(em, mk_tok(CAT_ESCAPE, 1'b0, offset_q, '0, line_q, column_q, 1'b1));
			end
			ACT_RESTART: begin
				n_mode   = MODE_NEWLINE;
				n_phase  = PH_NORMAL;
				n_cont   = 2'd0;
				n_offset = '0;
				n_line   = PW'(1);
				n_column = PW'(1);
				n_pstart = '0;
				n_pline  = PW'(1);
				n_pcol   = PW'(1);
				n_pcat   = CAT_ESCAPE;
				n_plen   = '0;
			end
			ACT_WRITE_CAT: begin
				// table write happens at the RAM; scanner state untouched
			end
		endcase

		if (em.count == 2'd2)
			em.tok[1].last = 1'b1;
		else if (em.count == 2'd1)
			em.tok[0].last = 1'b1;
	end

	assign emit = em;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NEWLINE;
			phase_q  <= PH_NORMAL;
			cont_q   <= 2'd0;
			offset_q <= '0;
			line_q   <= PW'(1);
			column_q <= PW'(1);
			pstart_q <= '0;
			pline_q  <= PW'(1);
			pcol_q   <= PW'(1);
			pcat_q   <= CAT_ESCAPE;
			plen_q   <= '0;
		end else if (en) begin
			mode_q   <= n_mode;
			phase_q  <= n_phase;
			cont_q   <= n_cont;
			offset_q <= n_offset;
			line_q   <= n_line;
			column_q <= n_column;
			pstart_q <= n_pstart;
			pline_q  <= n_pline;
			pcol_q   <= n_pcol;
			pcat_q   <= n_pcat;
			plen_q   <= n_plen;
		end
	end

	// continuation count is live exactly in the multibyte phases
	a_cont_phase: assert property (@(posedge clk) disable iff (!arst_n)
		((phase_q == PH_ESC_MB) || (phase_q == PH_CHAR_MB)) == (cont_q != 2'd0))
		else $error("continuation count out of step with phase");

	// an open token always holds at least one byte
	a_open_len: assert property (@(posedge clk) disable iff (!arst_n)
		((phase_q != PH_NORMAL) && (phase_q != PH_COMMENT)) |-> (plen_q != '0))
		else $error("open token with zero length");

	// a table write leaves the position counters alone
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(en && (step.action == ACT_WRITE_CAT)) |=> ($stable(offset_q) && $stable(line_q)))
		else $error("category write moved the position");
endmodule

// File: rtl/catcode_byte_tokenizer.sv
`timescale 1ns / 1ps
// catcode_byte_tokenizer: top level. A request and its category lookup are
// registered in stage 1, then its tokens go into the 4-entry token queue. One
// request is accepted per cycle while the queue has room for two more tokens,
// sustaining one byte per cycle, bounded by the one-token-per-cycle output port.
// Reset clears scanner state and the queue; the category table is not
// cleared and must be written before the bytes that use it.
module catcode_byte_tokenizer import ctt_pkg::*; #(
	parameter int unsigned CATEGORY_ENTRIES = CATEGORY_ENTRIES_DEF,
	parameter int unsigned POSITION_WIDTH   = POSITION_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ctt_chan_if.sink    bytes,
	ctt_chan_if.source  tokens
);
	localparam int unsigned TAB_AW  = $clog2(CATEGORY_ENTRIES);
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
	localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

	// ---------------------------------------------------------------
	// Stage 0: accept a request and start the category lookup.
	// Table writes land at accept time, so a byte accepted in the next
	// cycle already reads the new entry.
	// ---------------------------------------------------------------
	logic             accept;
	logic             proc;
	logic             valid_s1;
	req_t             req_s1;
	logic [CAT_W-1:0] cat_rd;
	req_t             req_in;

	assign req_in = bytes.payload;
	assign accept = bytes.valid && bytes.ready;

	ctt_ram #(
		.WIDTH(CAT_W),
		.DEPTH(CATEGORY_ENTRIES)
	) u_cat_table (
		.clk  (clk),
		.we   (accept && (req_in.action == ACT_WRITE_CAT)),
		.waddr(TAB_AW'(req_in.byte_value)),
		.wdata(req_in.category_value),
		.re   (accept),
		.raddr(TAB_AW'(req_in.byte_value)),
		.rdata(cat_rd)
	);

	// ---------------------------------------------------------------
	// Stage 1: request register. The lookup result and this register
	// stay together while the stage stalls, since the RAM only reads
	// on accept.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (proc)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_s1 <= req_in;
	end

	// ---------------------------------------------------------------
	// Scanner core: one request per cycle while the queue has room, up to two tokens out.
	// ---------------------------------------------------------------
	step_t step;
	emit_t emit;

	assign step.action     = req_s1.action;
	assign step.byte_value = req_s1.byte_value;
	assign step.cat        = cat_rd;

	ctt_core #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (proc),
		.step  (step),
		.emit  (emit)
	);

	// ---------------------------------------------------------------
	// Token queue. The stage-1 request retires only when two slots are
	// free, so the worst case (closing a word plus a newline, or a
	// pending token plus the end marker) always fits.
	// ---------------------------------------------------------------
	tok_t            q_mem [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CW-1:0] count_q;
	logic            pop;
	logic [1:0]      push_n;

	assign proc   = valid_s1 && (count_q <= Q_CW'(Q_DEPTH - 2));
	assign bytes.ready = !valid_s1 || proc;

	assign push_n = proc ? emit.count : 2'd0;
	assign pop    = tokens.valid && tokens.ready;

	assign tokens.valid   = (count_q != '0);
	assign tokens.payload = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			q_mem[wr_ptr_q] <= emit.tok[0];
		if (push_n == 2'd2)
			q_mem[wr_ptr_q + Q_AW'(1)] <= emit.tok[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_AW'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			count_q <= count_q + Q_CW'(push_n) - Q_CW'(pop);
		end
	end

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_CW'(Q_DEPTH))
		else $error("token queue overflow");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(tokens.valid && tokens.payload.end_marker) |-> tokens.payload.last)
		else $error("end marker not flagged as last");

	a_line_nz: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid |-> (tokens.payload.line != '0) && (tokens.payload.column != '0))
		else $error("token with zero line or column");
endmodule

// File: dv/catcode_byte_tokenizer_test.sv
`timescale 1ns / 1ps
// catcode_byte_tokenizer_test: self-checking bench for the catcode byte tokenizer.
// Depends on ctt_pkg, ctt_chan_if and the catcode_byte_tokenizer RTL; reads no files.
module catcode_byte_tokenizer_test import ctt_pkg::*;;

	localparam int unsigned RANDOM_ITEMS    = 1500;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned DRAIN_SLACK     = 8;
	localparam int unsigned CYCLE_LIMIT     = 2000000;

	// Shadow of the tokenizer: category map, scan state, pending token, and the
	// queue of tokens still owed by the block.
	class token_scoreboard;
		logic [CAT_W-1:0] cat_map [CATEGORY_ENTRIES_DEF];
		mode_t            spacing;
		phase_t           phase;
		int unsigned      cont_left;
		logic [31:0]      offset, cur_line, cur_col;
		logic [31:0]      tok_start, tok_line, tok_col;
		logic [CAT_W-1:0] tok_cat;
		logic [LEN_W-1:0] tok_len;
		tok_t             expected_q[$];
		int unsigned      mismatches, tokens_checked, newline_tokens, end_markers;
		int unsigned      double_steps;

		function new();
			foreach (cat_map[i])
				cat_map[i] = CAT_ESCAPE;
			restart();
		endfunction

		function void restart();
			spacing   = MODE_NEWLINE;
			phase     = PH_NORMAL;
			cont_left = 0;
			offset    = '0;
			cur_line  = 32'd1;
			cur_col   = 32'd1;
			tok_start = '0;
			tok_line  = 32'd1;
			tok_col   = 32'd1;
			tok_cat   = CAT_ESCAPE;
			tok_len   = '0;
		endfunction

		function void push(logic [CAT_W-1:0] c, logic nl, logic [31:0] s,
				logic [LEN_W-1:0] len, logic [31:0] ln, logic [31:0] col, logic em);
			tok_t t;
			t.category     = c;
			t.is_newline   = nl;
			t.start_offset = s;
			t.byte_length  = len;
			t.line         = ln;
			t.column       = col;
			t.end_marker   = em;
			t.last         = 1'b0;
			expected_q.push_back(t);
		endfunction

		function void push_pending();
			push(tok_cat, 1'b0, tok_start, tok_len, tok_line, tok_col, 1'b0);
		endfunction

		function void bump_col();
			if (cur_col != '1)
				cur_col++;
		endfunction

		function void grow_len();
			if (tok_len != LEN_MAX)
				tok_len++;
		endfunction

		function int unsigned utf8_len(logic [7:0] b);
			if (b[7:5] == 3'b110)
				return 2;
			if (b[7:4] == 4'b1110)
				return 3;
			if (b[7:3] == 5'b11110)
				return 4;
			return 1;
		endfunction

		function void open_token(logic [CAT_W-1:0] c);
			tok_start = offset;
			tok_line  = cur_line;
			tok_col   = cur_col;
			tok_cat   = c;
			tok_len   = 16'd1;
			offset++;
			bump_col();
		endfunction

		function void feed(logic [7:0] b);
			logic [CAT_W-1:0] c;
			logic [31:0]      sp_start, sp_col;
			c = cat_map[b];
			case (phase)
				PH_COMMENT: begin
					if (b != NL_BYTE) begin
						offset++;
						bump_col();
						return;
					end
					phase = PH_NORMAL;
				end
				PH_ESC_SEEN: begin
					offset++;
					grow_len();
					bump_col();
					// letter test wins, even over a newline or a UTF-8 lead
					if (c == CAT_LETTER) begin
						phase = PH_WORD;
						return;
					end
					if (utf8_len(b) > 1) begin
						cont_left = utf8_len(b) - 1;
						phase     = PH_ESC_MB;
						return;
					end
					spacing = MODE_MIDDLE;
					phase   = PH_NORMAL;
					push_pending();
					return;
				end
				PH_WORD: begin
					if (c == CAT_LETTER) begin
						offset++;
						grow_len();
						bump_col();
						return;
					end
					// word closes, then this byte is scanned afresh
					spacing = MODE_SKIP;
					phase   = PH_NORMAL;
					push_pending();
				end
				PH_ESC_MB, PH_CHAR_MB: begin
					offset++;
					grow_len();
					if (cont_left > 0)
						cont_left--;
					if (cont_left == 0) begin
						spacing = MODE_MIDDLE;
						phase   = PH_NORMAL;
						push_pending();
					end
					return;
				end
				default: phase = PH_NORMAL;
			endcase

			if (b == NL_BYTE) begin
				push(CAT_SPACE, 1'b1, offset, 16'd1, cur_line, cur_col, 1'b0);
				offset++;
				if (cur_line != '1)
					cur_line++;
				cur_col = 32'd1;
				spacing = MODE_NEWLINE;
				return;
			end
			if (c == CAT_SPACE) begin
				sp_start = offset;
				sp_col   = cur_col;
				offset++;
				bump_col();
				if (spacing != MODE_MIDDLE)
					return;
				spacing = MODE_SKIP;
				push(CAT_SPACE, 1'b0, sp_start, 16'd1, cur_line, sp_col, 1'b0);
				return;
			end
			if (c == CAT_IGNORE) begin
				offset++;
				bump_col();
				return;
			end
			if (c == CAT_COMMENT) begin
				offset++;
				bump_col();
				spacing = MODE_SKIP;
				phase   = PH_COMMENT;
				return;
			end
			if (c == CAT_ESCAPE) begin
				open_token(CAT_ESCAPE);
				phase = PH_ESC_SEEN;
				return;
			end
			open_token(c);
			if (utf8_len(b) > 1) begin
				cont_left = utf8_len(b) - 1;
				phase     = PH_CHAR_MB;
				return;
			end
			spacing = MODE_MIDDLE;
			push_pending();
		endfunction

		function void finish_input();
			case (phase)
				PH_ESC_SEEN, PH_ESC_MB, PH_CHAR_MB: begin
					spacing = MODE_MIDDLE;
					push_pending();
				end
				PH_WORD: begin
					spacing = MODE_SKIP;
					push_pending();
				end
				default: ;
			endcase
			phase     = PH_NORMAL;
			cont_left = 0;
			push(CAT_ESCAPE, 1'b0, offset, '0, cur_line, cur_col, 1'b1);
		endfunction

		// Called for every accepted request.
		function void note_request(req_t r);
			int unsigned before_n;
			before_n = expected_q.size();
			case (r.action)
				ACT_BYTE:      feed(r.byte_value);
				ACT_WRITE_CAT: cat_map[r.byte_value] = r.category_value;
				ACT_END:       finish_input();
				ACT_RESTART:   restart();
				default:       ;
			endcase
			if (expected_q.size() > before_n)
				expected_q[expected_q.size() - 1].last = 1'b1;
			if (expected_q.size() - before_n == 2)
				double_steps++;
		endfunction

		function string show(tok_t t);
			return $sformatf("cat=%0d nl=%0b start=%0d len=%0d line=%0d col=%0d end=%0b last=%0b",
				t.category, t.is_newline, t.start_offset, t.byte_length, t.line,
				t.column, t.end_marker, t.last);
		endfunction

		function void flag(string what, string want_s, string got_s);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: %s\n  expected %s\n  actual   %s", what, want_s, got_s);
		endfunction

		// Called for every accepted token.
		function void check_token(tok_t got);
			tok_t  want;
			string diff;
			tokens_checked++;
			if (got.is_newline === 1'b1)
				newline_tokens++;
			if (got.end_marker === 1'b1)
				end_markers++;
			if (expected_q.size() == 0) begin
				flag("token with none outstanding", "none", show(got));
				return;
			end
			want = expected_q.pop_front();
			diff = "";
			if (got.category !== want.category)         diff = {diff, " category"};
			if (got.is_newline !== want.is_newline)     diff = {diff, " is_newline"};
			if (got.start_offset !== want.start_offset) diff = {diff, " start_offset"};
			if (got.byte_length !== want.byte_length)   diff = {diff, " byte_length"};
			if (got.line !== want.line)                 diff = {diff, " line"};
			if (got.column !== want.column)             diff = {diff, " column"};
			if (got.end_marker !== want.end_marker)     diff = {diff, " end_marker"};
			if (got.last !== want.last)                 diff = {diff, " last"};
			if (diff != "")
				flag({"field", diff}, show(want), show(got));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ctt_chan_if #(.data_t(req_t)) bytes_if ();
	ctt_chan_if #(.data_t(tok_t)) tokens_if ();

	catcode_byte_tokenizer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes_if),
		.tokens (tokens_if)
	);

	token_scoreboard sb = new();

	int unsigned src_idle_pct  = 0;   // chance per request of a sender gap
	int unsigned sink_idle_pct = 0;   // chance per cycle of a receiver stall
	int unsigned sink_gap_left = 0;
	int unsigned counted_items = 0;   // requests sent, ignored bytes and table writes excluded
	int unsigned requests_sent = 0;
	int unsigned cycle_count   = 0;
	bit          hold_off_go     = 1'b0;
	bit          hold_off_active = 1'b0;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Watchdog: a missing token or a hung handshake ends here.
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles, %0d tokens outstanding", cycle_count,
			sb.expected_q.size());
		$display("FAIL");
		$finish;
	end

	// Monitor: sample both channels at the rising edge. The request is noted
	// before the token is checked; since a request is registered before its tokens
	// enter the queue, a token never depends on the request accepted at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (bytes_if.valid && bytes_if.ready)
				sb.note_request(bytes_if.payload);
			if (tokens_if.valid && tokens_if.ready)
				sb.check_token(tokens_if.payload);
		end
	end

	// Long receiver hold-off, timed here so the sender keeps offering requests
	// and the token queue fills until the block stalls its input.
	initial begin
		wait (hold_off_go);
		@(posedge clk);
		hold_off_active = 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off_active = 1'b0;
	end

	// Receiver: ready changes at the falling edge, and stalls come in bursts.
	always @(negedge clk) begin
		if (hold_off_active) begin
			tokens_if.ready <= 1'b0;
		end else if (sink_gap_left != 0) begin
			tokens_if.ready <= 1'b0;
			sink_gap_left   <= sink_gap_left - 1;
		end else if ($urandom_range(0, 99) < sink_idle_pct) begin
			tokens_if.ready <= 1'b0;
			sink_gap_left   <= $urandom_range(0, 6);
		end else begin
			tokens_if.ready <= 1'b1;
		end
	end

	// Sender: called at a falling edge, returns at the falling edge after the
	// request is taken. Valid stays high into the next request unless a gap
	// is drawn, so back-to-back requests see a single assignment per edge.
	task automatic send_request(input req_t r);
		int unsigned gap;
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			gap = $urandom_range(1, 7);
			bytes_if.valid   <= 1'b0;
			bytes_if.payload <= req_t'($urandom);  // junk while idle
			repeat (gap) @(negedge clk);
		end
		bytes_if.valid   <= 1'b1;
		bytes_if.payload <= r;
		@(posedge clk);
		while (!bytes_if.ready)
			@(posedge clk);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic put_byte(input logic [7:0] b);
		req_t r;
		r.action         = ACT_BYTE;
		r.byte_value     = b;
		r.category_value = 4'($urandom);
		if (sb.cat_map[b] != CAT_IGNORE)
			counted_items++;
		send_request(r);
	endtask

	task automatic put_write(input logic [7:0] idx, input logic [CAT_W-1:0] c);
		req_t r;
		r.action         = ACT_WRITE_CAT;
		r.byte_value     = idx;
		r.category_value = c;
		send_request(r);
	endtask

	task automatic put_action(input action_t a);
		req_t r;
		r.action         = a;
		r.byte_value     = 8'($urandom);
		r.category_value = 4'($urandom);
		counted_items++;
		send_request(r);
	endtask

	// Drop valid, wait until every owed token has come, then wait out DRAIN_SLACK.
	task automatic wait_drained();
		bytes_if.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
		@(negedge clk);
	endtask

	// Any category with no special meaning to the scanner.
	function automatic logic [CAT_W-1:0] plain_cat();
		logic [CAT_W-1:0] c;
		do
			c = 4'($urandom);
		while (c == CAT_ESCAPE || c == CAT_IGNORE || c == CAT_SPACE ||
			c == CAT_LETTER || c == CAT_COMMENT);
		return c;
	endfunction

	// A non-newline byte of the wanted category under the current map, else random.
	function automatic logic [7:0] pick_byte(input logic [CAT_W-1:0] c);
		logic [7:0] b;
		for (int i = 0; i < 64; i++) begin
			b = 8'($urandom);
			if (sb.cat_map[b] == c && b != NL_BYTE)
				return b;
		end
		for (int i = 0; i < 256; i++) begin
			if (sb.cat_map[i] == c && 8'(i) != NL_BYTE)
				return 8'(i);
		end
		return 8'($urandom);
	endfunction

	function automatic logic [CAT_W-1:0] base_cat(input logic [7:0] i);
		if ((i >= "a" && i <= "z") || (i >= "A" && i <= "Z"))
			return CAT_LETTER;
		if (i == "\\")
			return CAT_ESCAPE;
		if (i == "%")
			return CAT_COMMENT;
		if (i == " " || i == 8'h09)
			return CAT_SPACE;
		if (i == 8'h00 || i == 8'h7F)
			return CAT_IGNORE;
		return plain_cat();
	endfunction

	// Second scheme: extra letters (newline and UTF-8 leads among them), a
	// second escape, comment and space character, more ignored bytes.
	function automatic bit is_alt_key(input logic [7:0] i);
		return i == "@" || (i >= "0" && i <= "3") || i == NL_BYTE ||
			(i >= 8'hC0 && i <= 8'hC7) || (i >= 8'hE0 && i <= 8'hE3) ||
			i == "!" || i == "#" || i == "~" || (i >= 8'h01 && i <= 8'h04);
	endfunction

	function automatic logic [CAT_W-1:0] alt_cat(input logic [7:0] i);
		if (i == "!")
			return CAT_ESCAPE;
		if (i == "#")
			return CAT_COMMENT;
		if (i == "~")
			return CAT_SPACE;
		if (i >= 8'h01 && i <= 8'h04)
			return CAT_IGNORE;
		return CAT_LETTER;
	endfunction

	task automatic apply_scheme(input bit alt);
		for (int i = 0; i < 256; i++) begin
			if (is_alt_key(8'(i)))
				put_write(8'(i), alt ? alt_cat(8'(i)) : base_cat(8'(i)));
		end
	endtask

	// One piece of mostly well-formed text with random content, or noise.
	task automatic emit_chunk();
		int unsigned kind, n, len;
		logic [7:0]  b;
		bit          cut;
		kind = $urandom_range(0, 99);
		cut  = 1'b0;
		if (kind < 25) begin
			n = $urandom_range(1, 8);
			repeat (n) put_byte(pick_byte(CAT_LETTER));
		end else if (kind < 40) begin
			// control word, sometimes followed by a space that must vanish
			put_byte(pick_byte(CAT_ESCAPE));
			n = $urandom_range(1, 6);
			repeat (n) put_byte(pick_byte(CAT_LETTER));
			if ($urandom_range(0, 1))
				put_byte(pick_byte(CAT_SPACE));
		end else if (kind < 48) begin
			// control symbol
			put_byte(pick_byte(CAT_ESCAPE));
			case ($urandom_range(0, 3))
				0: put_byte(pick_byte(CAT_SPACE));
				1: put_byte(NL_BYTE);
				2: put_byte(pick_byte(plain_cat()));
				default: put_byte(8'($urandom));
			endcase
		end else if (kind < 60) begin
			n = $urandom_range(1, 4);
			repeat (n) put_byte(pick_byte(CAT_SPACE));
		end else if (kind < 68) begin
			put_byte(NL_BYTE);
		end else if (kind < 74) begin
			put_byte(pick_byte(CAT_COMMENT));
			n = $urandom_range(0, 6);
			repeat (n) begin
				b = 8'($urandom);
				put_byte(b == NL_BYTE ? b + 8'd1 : b);
			end
			if ($urandom_range(0, 3) != 0)
				put_byte(NL_BYTE);
		end else if (kind < 82) begin
			// UTF-8 character, maybe after an escape, now and then cut by end of input
			if ($urandom_range(0, 2) == 0)
				put_byte(pick_byte(CAT_ESCAPE));
			len = $urandom_range(2, 4);
			case (len)
				2: b = {3'b110, 5'($urandom)};
				3: b = {4'b1110, 4'($urandom)};
				default: b = {5'b11110, 3'($urandom)};
			endcase
			put_byte(b);
			n = len - 1;
			if ($urandom_range(0, 7) == 0) begin
				n   = $urandom_range(0, len - 2);
				cut = 1'b1;
			end
			repeat (n) put_byte({2'b10, 6'($urandom)});
			if (cut)
				put_action(ACT_END);
		end else if (kind < 88) begin
			n = $urandom_range(1, 3);
			repeat (n) put_byte(pick_byte(plain_cat()));
		end else if (kind < 91) begin
			put_byte(pick_byte(CAT_IGNORE));
		end else if (kind < 96) begin
			put_byte(8'($urandom));
		end else if (kind == 96) begin
			put_action(ACT_END);
		end else if (kind == 97) begin
			put_action(ACT_RESTART);
		end else begin
			put_write(8'($urandom), 4'($urandom));
		end
	endtask

	// Hand-picked cases: dropped and collapsed spaces, words closed by a space
	// or a newline, escape then newline, comments, ignored bytes, multibyte
	// characters that swallow a newline, truncation at end of input, restart.
	task automatic run_directed();
		put_byte(" ");                 // dropped at start of line
		put_byte("a");
		put_byte(" ");                 // one space token
		put_byte(" ");                 // collapsed
		put_byte("\\");
		put_byte("a");
		put_byte(NL_BYTE);             // word and newline from one request
		put_byte("\\");
		put_byte("b");
		put_byte(" ");                 // space after a control word is dropped
		put_byte("\\");
		put_byte(NL_BYTE);             // escape plus newline, no newline token
		put_byte("%");
		put_byte(NL_BYTE);
		put_byte(8'h00);
		put_byte(8'hC3);
		put_byte(NL_BYTE);             // taken as a continuation byte
		put_byte("\\");
		put_byte(8'hE2);
		put_byte(8'h82);
		put_byte(8'hAC);
		put_byte(8'hFF);               // high byte, single-byte length
		put_byte(8'hF0);
		put_byte(8'h9F);
		put_action(ACT_END);           // truncated character, then end marker
		put_byte("%");
		put_action(ACT_END);           // comment in progress dropped
		put_byte("\\");
		put_action(ACT_RESTART);       // pending escape discarded
	endtask

	initial begin
		int unsigned pct_choice [4];
		int unsigned random_base, done, block;
		bit          paused;

		pct_choice       = '{0, 10, 30, 60};
		arst_n           = 1'b0;
		bytes_if.valid   = 1'b0;
		bytes_if.payload = '0;
		paused           = 1'b0;
		block            = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Every table entry written before any byte is scanned.
		src_idle_pct  = 20;
		sink_idle_pct = 20;
		for (int i = 0; i < 256; i++)
			put_write(8'(i), base_cat(8'(i)));
		run_directed();

		random_base = counted_items;
		done        = 0;
		while (done < RANDOM_ITEMS) begin
			// New table scheme and idling mix every few hundred requests
			if (done / 300 != block) begin
				block = done / 300;
				apply_scheme(block % 2 == 1);
				src_idle_pct  = pct_choice[$urandom_range(0, 3)];
				sink_idle_pct = pct_choice[$urandom_range(0, 3)];
			end
			if (!hold_off_go && done >= 600)
				hold_off_go = 1'b1;
			if (!paused && done >= 1000) begin
				paused = 1'b1;
				wait_drained();
			end
			if (done + 300 >= RANDOM_ITEMS) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			emit_chunk();
			done = counted_items - random_base;
		end
		put_action(ACT_END);
		wait_drained();

		$display("covered %0d requests over two table schemes; %0d tokens checked",
			requests_sent, sb.tokens_checked);
		$display("%0d newline tokens, %0d end markers, %0d two-token requests, %0d mismatches",
			sb.newline_tokens, sb.end_markers, sb.double_steps, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/ctt_pkg.sv
rtl/ctt_chan_if.sv
rtl/ctt_ram.sv
rtl/ctt_core.sv
rtl/catcode_byte_tokenizer.sv
dv/catcode_byte_tokenizer_test.sv
